>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SDCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define SDCC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> src/sdcc_pkg.sv
// ---------------------------------------------------------------------------
// sdcc_pkg
// shared types, widths and codes of the squared density cross-correlation core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdcc_pkg;

  localparam int SAMPLE_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int SQ_W         = 16;
  localparam int STEP_W       = 16;
  localparam int LAG_W        = 10;
  localparam int PROB_W       = 44;
  // each term pair is at most 2^31, at most SAMPLE_DEPTH of them
  localparam int SUM_W        = 32 + ADDR_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [15:0] electron_sample;
    logic signed [15:0] hole_sample;
    logic [LAG_W-1:0]  lag_index;
  } request_t;

  typedef struct packed {
    logic [LAG_W-1:0]  lag_echo;
    logic [PROB_W-1:0] probability;
    logic              status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic issue;
    logic scale;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lag_oob;
    logic last_issue;
    logic pipe_empty;
  } dp_status_t;

endpackage

>>> src/sdcc_ram.sv
// ---------------------------------------------------------------------------
// sdcc_ram
// generic memory, one write port and two registered read ports
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/sdcc_ctrl.sv
// ---------------------------------------------------------------------------
// sdcc_ctrl
// sequencer for request decode, lag walk, scaling and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcc_ctrl import sdcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       request_valid,
  input  logic [1:0] opcode,
  output logic       request_stall,
  output logic       result_valid,
  input  logic       result_stall,
  output ctrl_cmd_t  cmd,
  input  dp_status_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid_next;

  assign request_stall = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    cmd               = '0;
    result_valid_next = result_valid && result_stall;
    unique case (state)
      S_IDLE: begin
        if (request_valid) begin
          unique case (opcode)
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_QUERY: begin
              cmd.start  = 1'b1;
              state_next = stat.lag_oob ? S_FINISH : S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to be free
        if (!result_valid || !result_stall) begin
          cmd.load_out      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

>>> src/sdcc_datapath.sv
// ---------------------------------------------------------------------------
// sdcc_datapath
// square stores, multiply-accumulate pipeline, step scaling and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcc_datapath import sdcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  request_t          request,
  input  logic              cfg_write_enable,
  input  logic [STEP_W-1:0] cfg_write_data,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        stat,
  output result_t           result
);

  localparam int CMP_W  = (CNT_W > LAG_W) ? CNT_W : LAG_W;
  localparam int TOT_W  = SUM_W + 1;
  localparam int WIDE_W = (TOT_W > PROB_W) ? TOT_W : PROB_W;
  localparam logic [PROB_W-1:0] PROB_MAX = '1;

  // Q1.15 square, (x*x)>>15 saturated to 16 bits
  function automatic logic [SQ_W-1:0] square_q15(input logic signed [15:0] x);
    logic [15:0] mag;
    logic [31:0] prod;
    logic [16:0] sq;
    mag  = x[15] ? 16'(~x + 16'sd1) : 16'(x);
    prod = mag * mag;
    sq   = prod[31:15];
    return (sq > 17'd65535) ? 16'hFFFF : sq[15:0];
  endfunction

  logic [STEP_W-1:0] step_width;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] lag_addr;
  logic [LAG_W-1:0]  lag_echo;
  logic              oob;
  logic [ADDR_W-1:0] j;
  logic [CNT_W-1:0]  last_j;
  logic              rd_valid;
  logic              prod_valid;
  logic [31:0]       prod_a;
  logic [31:0]       prod_b;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  prod_hi;
  logic [31:0]       prod_lo;

  logic              wr_en;
  logic [SQ_W-1:0]   e_far;
  logic [SQ_W-1:0]   e_near;
  logic [SQ_W-1:0]   h_far;
  logic [SQ_W-1:0]   h_near;
  logic [ADDR_W-1:0] far_addr;
  logic [ADDR_W-1:0] req_lag_addr;
  logic [TOT_W-1:0]  total;

  assign wr_en        = cmd.append && (count < CNT_W'(SAMPLE_DEPTH));
  assign far_addr     = j + lag_addr;
  assign req_lag_addr = ADDR_W'(request.lag_index);

  assign stat.lag_oob    = CMP_W'(request.lag_index) >= CMP_W'(count);
  assign stat.last_issue = (CNT_W'(j) == last_j);
  assign stat.pipe_empty = !rd_valid && !prod_valid;

  // port a reads the far sample (j + lag), port b the near one (j)
  sdcc_ram #(.WIDTH(SQ_W), .DEPTH(SAMPLE_DEPTH)) u_e_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ADDR_W'(count)),
    .wdata   (square_q15(request.electron_sample)),
    .raddr_a (far_addr),
    .rdata_a (e_far),
    .raddr_b (j),
    .rdata_b (e_near)
  );

  sdcc_ram #(.WIDTH(SQ_W), .DEPTH(SAMPLE_DEPTH)) u_h_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (ADDR_W'(count)),
    .wdata   (square_q15(request.hole_sample)),
    .raddr_a (far_addr),
    .rdata_a (h_far),
    .raddr_b (j),
    .rdata_b (h_near)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_width <= STEP_RESET;
      count      <= '0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        step_width <= cfg_write_data;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lag_addr <= req_lag_addr;
      lag_echo <= request.lag_index;
      oob      <= stat.lag_oob;
      j        <= '0;
      last_j   <= count - CNT_W'(req_lag_addr) - CNT_W'(1);
      acc      <= '0;
    end else begin
      if (cmd.issue) begin
        j <= j + ADDR_W'(1);
      end
      if (prod_valid) begin
        acc <= acc + SUM_W'(prod_a) + SUM_W'(prod_b);
      end
    end
    if (rd_valid) begin
      prod_a <= e_far * h_near;
      prod_b <= e_near * h_far;
    end
    if (cmd.scale) begin
      prod_hi <= acc[SUM_W-1:16] * step_width;
      prod_lo <= acc[15:0] * step_width;
    end
    if (cmd.load_out) begin
      result.lag_echo <= lag_echo;
      result.status   <= oob;
      if (oob) begin
        result.probability <= '0;
      end else if (WIDE_W'(total) > WIDE_W'(PROB_MAX)) begin
        result.probability <= PROB_MAX;
      end else begin
        result.probability <= PROB_W'(total);
      end
    end
  end

  assign total = TOT_W'(prod_hi) + TOT_W'(prod_lo[31:16]);

endmodule

>>> src/squared_density_cross_correlation_core.sv
// ---------------------------------------------------------------------------
// squared_density_cross_correlation_core
// electron/hole squared-density store with per-lag cross-correlation queries
// ---------------------------------------------------------------------------
// Each request carries an opcode. A clear or an append is taken while the
// sequencer is idle and gives no result; an append squares both samples as
// Q1.15 and stores them, and is dropped once SAMPLE_DEPTH pairs are held. A
// query for lag i against n stored pairs runs in steps: decode, then one
// issue cycle per term while a single multiply-accumulate unit walks both
// stores (each store is a RAM read at j and j + i in the same cycle), a
// drain of the read and product registers, the step width multiply, and
// the load of the result register once it is free. A query with i not
// below n skips to that load and answers with status 1 and zero. Requests
// are held off while a query runs, but a finished result waits in its own
// register so clears and appends go on being taken. The stores have no
// reset and need no clearing pass; step_width resets to 65535.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module squared_density_cross_correlation_core import sdcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              request_valid,
  output logic              request_stall,
  input  request_t          request,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  // step width register
  input  logic              cfg_write_enable,
  input  logic [STEP_W-1:0] cfg_write_data
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // sequencer: decodes requests and paces the lag walk
  sdcc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .opcode        (request.opcode),
    .request_stall (request_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cmd           (cmd),
    .stat          (stat)
  );

  // stores, accumulator, scaling and the result register
  sdcc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .request          (request),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .cmd              (cmd),
    .stat             (stat),
    .result           (result)
  );

  // a pending result is never overwritten
  `SDCC_NEVER(a_no_overwrite, cmd.load_out && result_valid && result_stall, "result overwritten")
  // an out-of-range answer always carries zero
  `SDCC_ASSERT(a_oob_zero, result_valid && result.status |-> result.probability == '0, "oob result not zero")
  // a new result only appears after a load
  `SDCC_ASSERT(a_rise_loaded, $rose(result_valid) |-> $past(cmd.load_out), "result without load")

endmodule

>>> test/tb_squared_density_cross_correlation_core.sv
// ---------------------------------------------------------------------------
// tb_squared_density_cross_correlation_core
// self-checking bench for the squared density cross-correlation core
// ---------------------------------------------------------------------------
// Requests are sent with random idle gaps while the result side stalls at
// random. Every accepted request goes into a scoreboard that keeps its own
// copy of the squared sample stores, the pair count and the step width. It
// works out the answer to each query when the query is taken. Each result
// is checked field by field against the oldest waiting answer. The run
// starts with a short directed sequence and then moves on to random
// clear/append/query sessions under several step widths.
`timescale 1ns / 1ps

module tb_squared_density_cross_correlation_core;
  import sdcc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint unsigned PROB_MAX = (64'd1 << PROB_W) - 64'd1;
  // a clear or an append is finished once it is taken, this is plenty of margin
  localparam int SETTLE_CYCLES = 16;

  // -------------------------------------------------------------------------
  // scoreboard: shadow stores and expected answers
  // -------------------------------------------------------------------------
  class separation_scoreboard;
    logic [SQ_W-1:0]   e_sq[SAMPLE_DEPTH];
    logic [SQ_W-1:0]   h_sq[SAMPLE_DEPTH];
    int unsigned       sample_total;
    logic [STEP_W-1:0] step;
    result_t           expected_results[$];
    int                errors;

    function new();
      foreach (e_sq[i]) begin
        e_sq[i] = '0;
        h_sq[i] = '0;
      end
      sample_total = 0;
      step = STEP_RESET;
      errors = 0;
    endfunction

    function void set_step(logic [STEP_W-1:0] value);
      step = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // q1.15 square, saturating at the top of 16 bits
    function logic [SQ_W-1:0] square(logic signed [15:0] x);
      longint mag;
      longint unsigned sq;
      mag = x;
      if (mag < 0) mag = -mag;
      sq = longint'(mag * mag) >> 15;
      if (sq > 65535) sq = 65535;
      return sq[SQ_W-1:0];
    endfunction

    // both cross terms over the overlap, then scaled by the step width
    function logic [PROB_W-1:0] lag_probability(int unsigned lag);
      longint unsigned acc, ef, hn, en, hf, hi, lo, r;
      acc = 0;
      for (int unsigned j = 0; j + lag < sample_total; j++) begin
        ef = e_sq[j + lag];
        hn = h_sq[j];
        en = e_sq[j];
        hf = h_sq[j + lag];
        acc += ef * hn + en * hf;
      end
      hi = (acc >> 16) * step;
      lo = ((acc & 64'hFFFF) * step) >> 16;
      if (hi > PROB_MAX) return PROB_MAX[PROB_W-1:0];
      r = hi + lo;
      if (r > PROB_MAX) r = PROB_MAX;
      return r[PROB_W-1:0];
    endfunction

    function void note_request(request_t req);
      result_t want;
      case (req.opcode)
        OP_CLEAR: begin
          sample_total = 0;
        end
        OP_APPEND: begin
          if (sample_total < SAMPLE_DEPTH) begin
            e_sq[sample_total] = square(req.electron_sample);
            h_sq[sample_total] = square(req.hole_sample);
            sample_total++;
          end
        end
        OP_QUERY: begin
          want.lag_echo = req.lag_index;
          if (req.lag_index >= sample_total) begin
            want.probability = '0;
            want.status = 1'b1;
          end else begin
            want.probability = lag_probability(req.lag_index);
            want.status = 1'b0;
          end
          expected_results.push_back(want);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no query waiting, expected none, actual lag %0d prob %0d status %0d",
                 $time, got.lag_echo, got.probability, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.lag_echo !== want.lag_echo) begin
        errors++;
        $display("%0t: lag_echo mismatch, expected %0d actual %0d",
                 $time, want.lag_echo, got.lag_echo);
      end
      if (got.probability !== want.probability) begin
        errors++;
        $display("%0t: probability mismatch at lag %0d, expected %0d actual %0d",
                 $time, want.lag_echo, want.probability, got.probability);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch at lag %0d, expected %0d actual %0d",
                 $time, want.lag_echo, want.status, got.status);
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // signals and block under test
  // -------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              request_valid;
  logic              request_stall;
  request_t          request;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              cfg_write_enable;
  logic [STEP_W-1:0] cfg_write_data;

  separation_scoreboard sb;
  // while set, neither side idles
  logic calm;

  squared_density_cross_correlation_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .request_valid    (request_valid),
    .request_stall    (request_stall),
    .request          (request),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // helpers
  // -------------------------------------------------------------------------

  // mostly back to back, some short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-range sample with the corners turning up often
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one request, hold it until taken, then maybe idle
  task automatic send_request(logic [1:0] op, logic signed [15:0] e_val,
                              logic signed [15:0] h_val, logic [LAG_W-1:0] lag);
    request_t req;
    int n;
    req.opcode = op;
    req.electron_sample = e_val;
    req.hole_sample = h_val;
    req.lag_index = lag;
    @(negedge clk);
    request = req;
    request_valid = 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    sb.note_request(req);
    n = calm ? 0 : gap_len();
    repeat (n) begin
      @(negedge clk);
      request_valid = 1'b0;
    end
  endtask

  task automatic append_pair(logic signed [15:0] e_val, logic signed [15:0] h_val);
    send_request(OP_APPEND, e_val, h_val, LAG_W'($urandom));
  endtask

  task automatic query_lag(logic [LAG_W-1:0] lag);
    send_request(OP_QUERY, pick_sample(), pick_sample(), lag);
  endtask

  // hold off requests until every answer is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    request_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_enable = 1'b0;
    sb.set_step(value);
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------

  // corners of the fields and each special case, under the reset step width
  task automatic directed_checks();
    send_request(OP_CLEAR, 16'sh0, 16'sh0, '0);     // clear on an empty store
    query_lag('0);                                  // nothing stored yet
    append_pair(16'sh8000, 16'sh8000);              // most negative squares up to 32768
    append_pair(16'sh7FFF, 16'sh7FFF);
    append_pair(16'sh8000, 16'sh7FFF);
    append_pair(16'sh0000, 16'shFFFF);              // tiny values square to zero
    query_lag(10'd0);                               // lag zero doubles the dot product
    query_lag(10'd1);
    query_lag(10'd3);                               // last lag still inside the store
    query_lag(10'd4);                               // lag equal to the count
    query_lag(10'd1023);                            // top lag, far out of range
    send_request(OP_UNUSED, 16'sh7FFF, 16'sh8000, 10'd2);  // ignored opcode
    query_lag(10'd2);
    send_request(OP_CLEAR, 16'shFFFF, 16'shFFFF, 10'h3FF);
    query_lag(10'd0);                               // stores kept but count is zero
    append_pair(16'sh0001, 16'sh4000);              // overwrites the first entry
    append_pair(16'sh5A5A, 16'shA5A5);
    query_lag(10'd0);
    query_lag(10'd1);
    query_lag(10'd2);
  endtask

  // sessions: a clear, a run of appends, then a mix of queries, appends, clears and unused opcodes
  task automatic random_sessions(int target);
    int done, k, n_ops, pick, total;
    done = 0;
    while (done < target) begin
      send_request(OP_CLEAR, pick_sample(), pick_sample(), LAG_W'($urandom));
      done++;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      repeat (k) append_pair(pick_sample(), pick_sample());
      done += k;
      n_ops = $urandom_range(4, 16);
      repeat (n_ops) begin
        total = sb.sample_total;
        pick = $urandom_range(0, 19);
        if (pick < 9 && total > 0) begin
          query_lag(LAG_W'($urandom_range(0, total - 1)));
        end else if (pick < 11 && total < SAMPLE_DEPTH) begin
          query_lag(LAG_W'($urandom_range(total, SAMPLE_DEPTH - 1)));
        end else if (pick < 12) begin
          query_lag(LAG_W'($urandom));
        end else if (pick < 17) begin
          append_pair(pick_sample(), pick_sample());
        end else if (pick < 18) begin
          send_request(OP_CLEAR, pick_sample(), pick_sample(), LAG_W'($urandom));
        end else if (pick < 19) begin
          // noise, does not count toward the target
          send_request(OP_UNUSED, pick_sample(), pick_sample(), LAG_W'($urandom));
          done--;
        end else begin
          query_lag(LAG_W'(total == 0 ? 0 : total - 1));
        end
        done++;
      end
    end
  endtask

  // result side: free runs broken by stall bursts of random length
  initial begin
    result_stall = 1'b0;
    forever begin
      if (calm) begin
        @(negedge clk);
        result_stall = 1'b0;
      end else begin
        repeat ($urandom_range(1, 30)) begin
          @(negedge clk);
          result_stall = 1'b0;
        end
        repeat (gap_len()) begin
          @(negedge clk);
          result_stall = calm ? 1'b0 : 1'b1;
        end
      end
    end
  end

  // results are taken at the edge where valid is high and stall is low
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
    end
  end

  // generous ceiling, the slowest correct run is well under a tenth of this
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new();
    calm = 1'b0;
    rst = 1'b1;
    request_valid = 1'b0;
    request = '0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset step width first, then the extremes and some random widths
    directed_checks();
    write_step(16'd0);
    random_sessions(80);
    write_step(16'hFFFF);
    random_sessions(60);
    write_step(16'd1);
    random_sessions(80);
    write_step(16'h8000);
    calm = 1'b1;
    random_sessions(60);
    calm = 1'b0;
    write_step(16'($urandom));
    random_sessions(80);
    write_step(16'($urandom));
    random_sessions(80);

    // drain, then give the block time to show anything stray
    settle();
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sdcc_pkg.sv
src/sdcc_ram.sv
src/sdcc_ctrl.sv
src/sdcc_datapath.sv
src/squared_density_cross_correlation_core.sv
test/tb_squared_density_cross_correlation_core.sv
